// ===== rtl/tpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, codes and the CRC-16 byte update for the telecommand packet
// checker.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int unsigned LENGTH_OFFSET_DEFAULT = 7;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_ID = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CATEGORY   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 2'd2;

  localparam logic [6:0]  PROCESS_ID_RESET = 7'd11;
  localparam logic [3:0]  CATEGORY_RESET   = 4'd12;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

  localparam logic [7:0] TYPE_TC_181    = 8'd181;
  localparam logic [7:0] TYPE_TC_9      = 8'd9;
  localparam logic [7:0] SUBTYPE_TC_129 = 8'd129;
  localparam logic [5:0] SIZE_TC_9      = 6'd18;

  // byte positions within the packet
  localparam logic [15:0] POS_ID_HI   = 16'd0;
  localparam logic [15:0] POS_ID_LO   = 16'd1;
  localparam logic [15:0] POS_LEN_HI  = 16'd4;
  localparam logic [15:0] POS_LEN_LO  = 16'd5;
  localparam logic [15:0] POS_TYPE    = 16'd7;
  localparam logic [15:0] POS_SUBTYPE = 16'd8;
  localparam logic [15:0] MIN_LAST_POS = 16'd8;

  typedef enum logic [2:0] {
    ST_VALID       = 3'd0,
    ST_BAD_PID     = 3'd1,
    ST_WRONG_LEN   = 3'd2,
    ST_BAD_CRC     = 3'd3,
    ST_BAD_TYPE    = 3'd4,
    ST_BAD_SUBTYPE = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] crc_calc;
    logic [15:0] received_crc;
    logic [7:0]  service_type_out;
    logic [7:0]  service_subtype_out;
  } out_item_t;

  // what the front hands over at the end of a packet
  typedef struct packed {
    logic [15:0] last_pos;
    logic [15:0] id_bytes;
    logic [15:0] length_word;
    logic [7:0]  type_byte;
    logic [7:0]  subtype_byte;
    logic [15:0] running_crc;
    logic [15:0] byte_delay;
  } pkt_summary_t;

  typedef struct packed {
    logic [6:0]  process_id;
    logic [3:0]  category;
    logic [15:0] max_length;
  } cfg_regs_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // packet size for service type 181, zero when the subtype is unknown
  function automatic logic [5:0] size_for_181(input logic [7:0] sub);
    logic [5:0] s;
    case (sub)
      8'd3, 8'd30, 8'd60, 8'd61: s = 6'd12;
      8'd20, 8'd24, 8'd27, 8'd28: s = 6'd14;
      8'd21, 8'd40: s = 6'd20;
      8'd50: s = 6'd50;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tpc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_front
// Per-byte packet tracking: byte count, header capture, two-byte delay line
// and running CRC. Hands a packet summary to the queue on the last byte.
// ----------------------------------------------------------------------------
module tpc_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tpc_pkg::in_item_t     in_item,
  input  wire logic                  q_full,
  output logic                       push,
  output tpc_pkg::pkt_summary_t      push_data
);
  import tpc_pkg::*;

  logic [15:0] running_crc, running_crc_next;
  logic [15:0] byte_index;
  logic [15:0] id_bytes, id_bytes_next;
  logic [15:0] length_word, length_word_next;
  logic [7:0]  type_byte, type_byte_next;
  logic [7:0]  subtype_byte, subtype_byte_next;
  logic [15:0] byte_delay, byte_delay_next;
  logic        accept;
  logic [7:0]  b;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_item.data_byte;

  always_comb begin
    running_crc_next  = (byte_index >= 16'd2) ? crc_byte(running_crc, byte_delay[15:8])
                                              : running_crc;
    byte_delay_next   = {byte_delay[7:0], b};
    id_bytes_next     = id_bytes;
    length_word_next  = length_word;
    type_byte_next    = type_byte;
    subtype_byte_next = subtype_byte;
    case (byte_index)
      POS_ID_HI:   id_bytes_next[15:8]    = b;
      POS_ID_LO:   id_bytes_next[7:0]     = b;
      POS_LEN_HI:  length_word_next[15:8] = b;
      POS_LEN_LO:  length_word_next[7:0]  = b;
      POS_TYPE:    type_byte_next         = b;
      POS_SUBTYPE: subtype_byte_next      = b;
      default: ;
    endcase
  end

  assign push = accept && in_item.last_byte;

  always_comb begin
    push_data.last_pos     = byte_index;
    push_data.id_bytes     = id_bytes_next;
    push_data.length_word  = length_word_next;
    push_data.type_byte    = type_byte_next;
    push_data.subtype_byte = subtype_byte_next;
    push_data.running_crc  = running_crc_next;
    push_data.byte_delay   = byte_delay_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      running_crc  <= CRC_INIT;
      byte_index   <= '0;
      id_bytes     <= '0;
      length_word  <= '0;
      type_byte    <= '0;
      subtype_byte <= '0;
      byte_delay   <= '0;
    end else if (accept) begin
      running_crc  <= running_crc_next;
      id_bytes     <= id_bytes_next;
      length_word  <= length_word_next;
      type_byte    <= type_byte_next;
      subtype_byte <= subtype_byte_next;
      byte_delay   <= byte_delay_next;
      if (byte_index != 16'hFFFF) begin
        byte_index <= byte_index + 16'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    push |=> byte_index == 16'd0 && running_crc == CRC_INIT)
    else $error("front state not cleared after last beat");
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(byte_index))
    else $error("byte count moved without an accepted beat");
`endif

endmodule
`default_nettype wire

// ===== rtl/tpc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_queue
// Two-entry queue of packet summaries between front and back.
// ----------------------------------------------------------------------------
module tpc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire tpc_pkg::pkt_summary_t push_data,
  input  wire logic                  pop,
  output tpc_pkg::pkt_summary_t      head,
  output logic                       not_empty,
  output logic                       full
);
  import tpc_pkg::*;

  pkt_summary_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue pushed while full");
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ===== rtl/tpc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_back
// Configuration registers, acceptance checks on a queued packet summary and
// the result output register.
// ----------------------------------------------------------------------------
module tpc_back #(
  parameter int unsigned LENGTH_OFFSET = tpc_pkg::LENGTH_OFFSET_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [tpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tpc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire tpc_pkg::pkt_summary_t               head,
  input  wire logic                                head_valid,
  output logic                                     pop,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output tpc_pkg::out_item_t                       out_item
);
  import tpc_pkg::*;

  cfg_regs_t   cfg;
  status_t     status_next;
  logic [16:0] count;
  logic [16:0] total;
  logic [5:0]  need;
  logic [6:0]  pid;
  logic [3:0]  cat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.process_id <= PROCESS_ID_RESET;
      cfg.category   <= CATEGORY_RESET;
      cfg.max_length <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PROCESS_ID: cfg.process_id <= cfg_data[6:0];
        CFG_CATEGORY:   cfg.category   <= cfg_data[3:0];
        CFG_MAX_LENGTH: cfg.max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count = {1'b0, head.last_pos} + 17'd1;
  assign total = {1'b0, head.length_word} + 17'(LENGTH_OFFSET);
  assign need  = size_for_181(head.subtype_byte);
  assign pid   = {head.id_bytes[10:8], head.id_bytes[7:4]};
  assign cat   = head.id_bytes[3:0];

  always_comb begin
    if (head.last_pos < MIN_LAST_POS) begin
      status_next = ST_WRONG_LEN;
    end else if (pid != cfg.process_id || cat != cfg.category) begin
      status_next = ST_BAD_PID;
    end else if (head.last_pos == 16'hFFFF || total != count) begin
      status_next = ST_WRONG_LEN;
    end else if (head.length_word >= cfg.max_length) begin
      status_next = ST_WRONG_LEN;
    end else if (head.type_byte == TYPE_TC_181) begin
      if (need == 6'd0) begin
        status_next = ST_BAD_SUBTYPE;
      end else if (total != 17'(need)) begin
        status_next = ST_WRONG_LEN;
      end else if (head.running_crc != head.byte_delay) begin
        status_next = ST_BAD_CRC;
      end else begin
        status_next = ST_VALID;
      end
    end else if (head.type_byte == TYPE_TC_9) begin
      if (head.subtype_byte != SUBTYPE_TC_129) begin
        status_next = ST_BAD_SUBTYPE;
      end else if (total != 17'(SIZE_TC_9)) begin
        status_next = ST_WRONG_LEN;
      end else if (head.running_crc != head.byte_delay) begin
        status_next = ST_BAD_CRC;
      end else begin
        status_next = ST_VALID;
      end
    end else begin
      status_next = ST_BAD_TYPE;
    end
  end

  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.status              <= status_next;
      out_item.crc_calc            <= head.running_crc;
      out_item.received_crc        <= head.byte_delay;
      out_item.service_type_out    <= head.type_byte;
      out_item.service_subtype_out <= head.subtype_byte;
    end
  end

`ifndef SYNTHESIS
  a_valid_needs_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_VALID |->
      out_item.service_type_out == TYPE_TC_181 || out_item.service_type_out == TYPE_TC_9)
    else $error("valid status with unknown service type");
  a_valid_crc_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_VALID |->
      out_item.crc_calc == out_item.received_crc)
    else $error("valid status with crc mismatch");
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("result register not loaded on pop");
`endif

endmodule
`default_nettype wire

// ===== rtl/telecommand_packet_checker_top.sv =====
`default_nettype none
// A result beat passes the summary queue and then the output register.
// Throughput: one byte per cycle while the queue is not full; CRC is byte-wide.
// A two-entry summary queue lets bytes keep flowing while a result is stalled.
// Reset (rst, synchronous): clears packet state, queue and output valid, and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// telecommand_packet_checker_top
// Telecommand acceptance check with CRC-16: byte-wise front end, summary
// queue and judging back end.
// ----------------------------------------------------------------------------
module telecommand_packet_checker_top #(
  parameter int unsigned LENGTH_OFFSET = tpc_pkg::LENGTH_OFFSET_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [tpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire tpc_pkg::in_item_t                in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tpc_pkg::out_item_t                    out_item
);
  import tpc_pkg::*;

  pkt_summary_t push_data;
  pkt_summary_t head;
  logic         push;
  logic         pop;
  logic         q_full;
  logic         q_not_empty;

  tpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  tpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  tpc_back #(
    .LENGTH_OFFSET (LENGTH_OFFSET)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .head_valid (q_not_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

// ===== sim/telecommand_packet_checker_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// telecommand_packet_checker_top_tb
// Streams telecommand packets into the checker byte by byte. These cover short
// packets, every status, the register extremes, back-pressure and random
// packets. A local model of the acceptance check predicts each result beat,
// and every result is compared with it field by field.
// ----------------------------------------------------------------------------
module telecommand_packet_checker_top_tb;
  import tpc_pkg::*;

  localparam int IDLE_PCT    = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int LEN_OFFSET  = LENGTH_OFFSET_DEFAULT;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] KNOWN_181_SUBTYPES [0:10] =
    '{8'd3, 8'd30, 8'd60, 8'd61, 8'd20, 8'd24, 8'd27, 8'd28, 8'd21, 8'd40, 8'd50};

  typedef enum int {FLAW_NONE, FLAW_PID, FLAW_CAT, FLAW_LEN, FLAW_CRC} flaw_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;

  // model of the checker
  logic [6:0]  cfg_pid = PROCESS_ID_RESET;
  logic [3:0]  cfg_cat = CATEGORY_RESET;
  logic [15:0] cfg_max = MAX_LENGTH_RESET;
  logic [15:0] crc_acc = CRC_INIT;
  logic [15:0] beat_pos = '0;
  logic [15:0] hdr_id = '0;
  logic [15:0] len_field = '0;
  logic [7:0]  svc_type = '0;
  logic [7:0]  svc_sub = '0;
  logic [15:0] tail_bytes = '0;

  out_item_t   expected_verdicts[$];
  logic [7:0]  pkt[$];
  int          mismatch_count = 0;
  int          sent_beats = 0;
  int          in_idle_pct = IDLE_PCT;
  int          out_stall_pct = IDLE_PCT;
  int          hold_left = 0;

  telecommand_packet_checker_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic int unsigned tc181_packet_size(input logic [7:0] sub);
    case (sub)
      8'd3, 8'd30, 8'd60, 8'd61: return 12;
      8'd20, 8'd24, 8'd27, 8'd28: return 14;
      8'd21, 8'd40: return 20;
      8'd50: return 50;
      default: return 0;
    endcase
  endfunction

  function automatic status_t acceptance_status();
    int unsigned count;
    int unsigned total;
    int unsigned need;
    count = int'(beat_pos) + 1;
    if (count < 9) return ST_WRONG_LEN;
    if ({hdr_id[10:8], hdr_id[7:4]} != cfg_pid || hdr_id[3:0] != cfg_cat) return ST_BAD_PID;
    total = int'(len_field) + LEN_OFFSET;
    if (beat_pos == 16'hFFFF || total != count) return ST_WRONG_LEN;
    if (len_field >= cfg_max) return ST_WRONG_LEN;
    if (svc_type == TYPE_TC_181) begin
      need = tc181_packet_size(svc_sub);
      if (need == 0) return ST_BAD_SUBTYPE;
      if (total != need) return ST_WRONG_LEN;
    end else if (svc_type == TYPE_TC_9) begin
      if (svc_sub != SUBTYPE_TC_129) return ST_BAD_SUBTYPE;
      if (total != int'(SIZE_TC_9)) return ST_WRONG_LEN;
    end else begin
      return ST_BAD_TYPE;
    end
    if (crc_acc != tail_bytes) return ST_BAD_CRC;
    return ST_VALID;
  endfunction

  function automatic void absorb_byte(input in_item_t it);
    out_item_t r;
    if (beat_pos >= 2) crc_acc = crc16_ccitt_byte(crc_acc, tail_bytes[15:8]);
    tail_bytes = {tail_bytes[7:0], it.data_byte};
    case (beat_pos)
      POS_ID_HI:   hdr_id[15:8] = it.data_byte;
      POS_ID_LO:   hdr_id[7:0] = it.data_byte;
      POS_LEN_HI:  len_field[15:8] = it.data_byte;
      POS_LEN_LO:  len_field[7:0] = it.data_byte;
      POS_TYPE:    svc_type = it.data_byte;
      POS_SUBTYPE: svc_sub = it.data_byte;
      default: ;
    endcase
    if (!it.last_byte) begin
      if (beat_pos != 16'hFFFF) beat_pos++;
    end else begin
      r.status = acceptance_status();
      r.crc_calc = crc_acc;
      r.received_crc = tail_bytes;
      r.service_type_out = svc_type;
      r.service_subtype_out = svc_sub;
      expected_verdicts.push_back(r);
      crc_acc = CRC_INIT;
      beat_pos = '0;
      hdr_id = '0;
      len_field = '0;
      svc_type = '0;
      svc_sub = '0;
      tail_bytes = '0;
    end
  endfunction

  // result side: stall at random, or hold off for a counted stretch
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got %h", $time, out_item);
        mismatch_count++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("crc_calc", want.crc_calc, out_item.crc_calc);
        check_field("received_crc", want.received_crc, out_item.received_crc);
        check_field("service_type", want.service_type_out, out_item.service_type_out);
        check_field("service_subtype", want.service_subtype_out, out_item.service_subtype_out);
      end
    end
  end

  // all driver tasks start and end at a falling edge
  task automatic send_beat(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < in_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_item.data_byte = b;
    in_item.last_byte = l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(in_item);
    sent_beats++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic build_packet(input int size, input logic [7:0] ptype, input logic [7:0] psub,
                              input flaw_t flaw);
    logic [6:0]  pid;
    logic [3:0]  cat;
    logic [15:0] len;
    logic [15:0] crc;
    pkt.delete();
    repeat (size) pkt.push_back(8'($urandom_range(0, 255)));
    pid = cfg_pid;
    cat = cfg_cat;
    len = 16'(size - LEN_OFFSET);
    case (flaw)
      FLAW_PID: pid ^= 7'(1 << $urandom_range(0, 6));
      FLAW_CAT: cat ^= 4'(1 << $urandom_range(0, 3));
      FLAW_LEN: len ^= 16'(1 << $urandom_range(0, 15));
      default: ;
    endcase
    if (size > 0) pkt[0] = (pkt[0] & 8'hF8) | {5'b0, pid[6:4]};
    if (size > 1) pkt[1] = {pid[3:0], cat};
    if (size > 4) pkt[4] = len[15:8];
    if (size > 5) pkt[5] = len[7:0];
    if (size > 7) pkt[7] = ptype;
    if (size > 8) pkt[8] = psub;
    if (size >= 2) begin
      crc = CRC_INIT;
      for (int i = 0; i < size - 2; i++) crc = crc16_ccitt_byte(crc, pkt[i]);
      if (flaw == FLAW_CRC) crc ^= 16'(1 << $urandom_range(0, 15));
      pkt[size - 2] = crc[15:8];
      pkt[size - 1] = crc[7:0];
    end
  endtask

  task automatic send_service_packet(input flaw_t flaw);
    int idx;
    idx = $urandom_range(0, 11);
    if (idx == 11) begin
      build_packet(SIZE_TC_9, TYPE_TC_9, SUBTYPE_TC_129, flaw);
    end else begin
      build_packet(tc181_packet_size(KNOWN_181_SUBTYPES[idx]), TYPE_TC_181,
                   KNOWN_181_SUBTYPES[idx], flaw);
    end
    send_packet();
  endtask

  task automatic wait_drained();
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_PROCESS_ID: cfg_pid = val[6:0];
      CFG_CATEGORY:   cfg_cat = val[3:0];
      CFG_MAX_LENGTH: cfg_max = val;
      default: ;
    endcase
  endtask

  task automatic test_short_packets();
    build_packet(1, TYPE_TC_181, 8'd3, FLAW_NONE);
    send_packet();
    build_packet(2, TYPE_TC_181, 8'd3, FLAW_NONE);
    send_packet();
    build_packet(8, TYPE_TC_181, 8'd3, FLAW_NONE);
    send_packet();
  endtask

  task automatic test_each_status();
    build_packet(12, TYPE_TC_181, 8'd3, FLAW_NONE);
    send_packet();
    build_packet(SIZE_TC_9, TYPE_TC_9, SUBTYPE_TC_129, FLAW_NONE);
    send_packet();
    build_packet(14, TYPE_TC_181, 8'd20, FLAW_PID);
    send_packet();
    build_packet(14, TYPE_TC_181, 8'd24, FLAW_CAT);
    send_packet();
    build_packet(20, TYPE_TC_181, 8'd21, FLAW_LEN);
    send_packet();
    build_packet(12, TYPE_TC_181, 8'd61, FLAW_CRC);
    send_packet();
    build_packet(12, 8'hFF, 8'd3, FLAW_NONE);
    send_packet();
    build_packet(12, TYPE_TC_181, 8'd0, FLAW_NONE);
    send_packet();
    build_packet(14, TYPE_TC_9, 8'hFF, FLAW_NONE);
    send_packet();
    // known subtype, consistent length field, wrong size
    build_packet(12, TYPE_TC_181, 8'd50, FLAW_NONE);
    send_packet();
  endtask

  task automatic test_register_extremes();
    wait_drained();
    write_reg(CFG_PROCESS_ID, 16'h0000);
    write_reg(CFG_CATEGORY, 16'h0000);
    write_reg(CFG_MAX_LENGTH, 16'h0000);
    build_packet(12, TYPE_TC_181, 8'd3, FLAW_NONE);
    send_packet();
    wait_drained();
    write_reg(CFG_MAX_LENGTH, 16'hFFFF);
    build_packet(12, TYPE_TC_181, 8'd30, FLAW_NONE);
    send_packet();
    wait_drained();
    write_reg(CFG_PROCESS_ID, 16'hFFFF);
    write_reg(CFG_CATEGORY, 16'hFFFF);
    write_reg(CFG_MAX_LENGTH, 16'd5);
    // length field 5 sits on the limit, 43 is above it
    build_packet(12, TYPE_TC_181, 8'd60, FLAW_NONE);
    send_packet();
    build_packet(50, TYPE_TC_181, 8'd50, FLAW_NONE);
    send_packet();
    wait_drained();
    write_reg(CFG_MAX_LENGTH, 16'd6);
    write_reg(CFG_UNUSED, 16'h0000);
    build_packet(12, TYPE_TC_181, 8'd60, FLAW_NONE);
    send_packet();
    build_packet(SIZE_TC_9, TYPE_TC_9, SUBTYPE_TC_129, FLAW_NONE);
    send_packet();
    wait_drained();
    write_reg(CFG_PROCESS_ID, PROCESS_ID_RESET);
    write_reg(CFG_CATEGORY, CATEGORY_RESET);
    write_reg(CFG_MAX_LENGTH, MAX_LENGTH_RESET);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_left = HOLD_CYCLES;
    repeat (5) send_service_packet(FLAW_NONE);
    wait_drained();
  endtask

  task automatic test_random_packets();
    int start;
    int pkts;
    int kind;
    start = sent_beats;
    pkts = 0;
    while (sent_beats - start < 150 || pkts < 14) begin
      if (pkts == 4) begin
        wait_drained();
        write_reg(CFG_PROCESS_ID, 16'($urandom_range(0, 65535)));
        write_reg(CFG_CATEGORY, 16'($urandom_range(0, 65535)));
        write_reg(CFG_MAX_LENGTH, 16'($urandom_range(10, 300)));
      end
      if (pkts == 7) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      if (pkts == 12) begin
        in_idle_pct = IDLE_PCT;
        out_stall_pct = IDLE_PCT;
      end
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        send_service_packet(FLAW_NONE);
      end else if (kind < 80) begin
        send_service_packet(flaw_t'($urandom_range(1, 4)));
      end else begin
        if (kind < 87) begin
          build_packet($urandom_range(9, 30),
                       $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : TYPE_TC_181,
                       8'($urandom_range(0, 255)), FLAW_NONE);
        end else if (kind < 93) begin
          build_packet($urandom_range(9, 60), TYPE_TC_181,
                       KNOWN_181_SUBTYPES[$urandom_range(0, 10)], FLAW_NONE);
        end else begin
          pkt.delete();
          repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom_range(0, 255)));
        end
        send_packet();
      end
      pkts++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_short_packets();
    test_each_status();
    test_register_extremes();
    test_backpressure();
    test_random_packets();
    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
